>>> rtl/core/sha224_pkg.sv
// Shared types, constants and round table for the SHA-224 digest block.
`default_nettype none

package sha224_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] state8_t;
    typedef logic [15:0][31:0] window_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       shift_en;
        logic [7:0] shift_data;
        logic       init;
        logic       round_en;
    } ctl_t;

    localparam logic [5:0] BLOCK_END  = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [2:0] LAST_IDX   = 3'd6;

    localparam state8_t IV_INIT = {
        32'hbefa4fa4, 32'h64f98fa7, 32'h68581511, 32'hffc00b31,
        32'hf70e5939, 32'h3070dd17, 32'h367cd507, 32'hc1059ed8
    };

    localparam logic [63:0][31:0] K_TABLE = {
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

endpackage

`default_nettype wire

>>> rtl/core/sha224_message_digest.sv
// Top level of the SHA-224 digest block: byte intake, padding sequencer, chaining words.
//
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+--------------------------------------
//  in      | into      | in_valid, in_stall  | has_byte, data_byte, is_last
//  out     | out of    | out_valid, out_stall| digest_word, word_index, last_word
//
//  A byte that does not close a block leaves the sequencer in idle. The 64th byte of a block
//  runs the round states of the shared round unit, then a fold state. A last item adds the
//  pad bytes, a step where the zeros reach the length field (padding goes on into a second
//  block when the length spills), the eight length bytes, one or two compressions, then
//  seven transfers out.
//  rst_n clears the sequencer and loads the initial chaining value; in_stall is high outside
//  idle, through each compression and from a last item until the digest has gone out.
//  out_stall holds the current word.
`default_nettype none

module sha224_message_digest
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        has_byte,
    input  wire logic [7:0]  data_byte,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    import sha224_pkg::*;

    state_t        state_reg;
    state_t        state_next;
    state8_t       chain_reg;
    state8_t       chain_next;
    logic [60:0]   count_reg;
    logic [60:0]   count_next;
    logic [5:0]    fill_reg;
    logic [5:0]    fill_next;
    logic [5:0]    round_reg;
    logic [5:0]    round_next;
    logic [2:0]    idx_reg;
    logic [2:0]    idx_next;
    logic          pad_mode_reg;
    logic          pad_mode_next;
    logic          pad_first_reg;
    logic          pad_first_next;
    logic          final_reg;
    logic          final_next;

    ctl_t          ctl;
    state8_t       work;
    logic          in_accept;
    logic          out_accept;
    logic [63:0]   len_shift;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign len_shift  = {count_reg, 3'b000} << {fill_reg[2:0], 3'b000};

    sha224_compress u_compress
    (
        .clk       (clk),
        .ctl       (ctl),
        .round_idx (round_reg),
        .chain     (chain_reg),
        .work      (work)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (has_byte && fill_reg == BLOCK_END)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_mode_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (!pad_first_reg && fill_reg == LEN_POS)
                begin
                    state_next = ST_LEN;
                end
                else if (fill_reg == BLOCK_END)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_LEN:
            begin
                if (fill_reg == BLOCK_END)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                if (out_accept && idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl            = '0;
        chain_next     = chain_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        pad_mode_next  = pad_mode_reg;
        pad_first_next = pad_first_reg;
        final_next     = final_reg;
        in_stall       = 1'b1;
        out_valid      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_accept)
                begin
                    if (has_byte)
                    begin
                        ctl.shift_en   = 1'b1;
                        ctl.shift_data = data_byte;
                        count_next     = count_reg + 61'd1;
                        fill_next      = fill_reg + 6'd1;
                        ctl.init       = (fill_reg == BLOCK_END);
                    end
                    if (is_last)
                    begin
                        pad_mode_next  = 1'b1;
                        pad_first_next = 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                ctl.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
            end
            ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
            end
            ST_PAD:
            begin
                if (pad_first_reg || fill_reg != LEN_POS)
                begin
                    ctl.shift_en   = 1'b1;
                    ctl.shift_data = pad_first_reg ? PAD_BYTE : 8'h00;
                    ctl.init       = (fill_reg == BLOCK_END);
                    pad_first_next = 1'b0;
                    fill_next      = fill_reg + 6'd1;
                end
            end
            ST_LEN:
            begin
                ctl.shift_en   = 1'b1;
                ctl.shift_data = len_shift[63:56];
                fill_next      = fill_reg + 6'd1;
                if (fill_reg == BLOCK_END)
                begin
                    ctl.init   = 1'b1;
                    final_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_accept)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next       = 3'd0;
                        chain_next     = IV_INIT;
                        count_next     = '0;
                        fill_next      = '0;
                        pad_mode_next  = 1'b0;
                        pad_first_next = 1'b0;
                        final_next     = 1'b0;
                    end
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg     <= IV_INIT;
            count_reg     <= '0;
            fill_reg      <= '0;
            round_reg     <= '0;
            idx_reg       <= '0;
            pad_mode_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            pad_mode_reg  <= pad_mode_next;
            pad_first_reg <= pad_first_next;
            final_reg     <= final_next;
        end
    end

    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_IDX);

endmodule

`default_nettype wire

>>> rtl/core/sha224_compress.sv
// Block buffer, rolling message schedule and one-round-per-cycle compression unit.
`default_nettype none

module sha224_compress
(
    input  wire logic              clk,
    input  wire sha224_pkg::ctl_t  ctl,
    input  wire logic [5:0]        round_idx,
    input  wire sha224_pkg::state8_t chain,
    output sha224_pkg::state8_t    work
);
    import sha224_pkg::*;

    window_t win_reg;
    window_t win_next;
    state8_t work_reg;
    state8_t work_next;

    word_t s0_w;
    word_t s1_w;
    word_t sum1;
    word_t sum0;
    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    function automatic word_t ror(input word_t x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        s0_w = ror(win_reg[1], 7) ^ ror(win_reg[1], 18) ^ (win_reg[1] >> 3);
        s1_w = ror(win_reg[14], 17) ^ ror(win_reg[14], 19) ^ (win_reg[14] >> 10);
        sum1 = ror(work_reg[4], 6) ^ ror(work_reg[4], 11) ^ ror(work_reg[4], 25);
        sum0 = ror(work_reg[0], 2) ^ ror(work_reg[0], 13) ^ ror(work_reg[0], 22);
        ch   = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
             ^ (work_reg[1] & work_reg[2]);
        t1   = work_reg[7] + sum1 + ch + K_TABLE[round_idx] + win_reg[0];
        t2   = sum0 + maj;

        win_next  = win_reg;
        work_next = work_reg;

        if (ctl.shift_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], ctl.shift_data};
        end
        else if (ctl.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = s1_w + win_reg[9] + s0_w + win_reg[0];
        end

        if (ctl.init)
        begin
            work_next = chain;
        end
        else if (ctl.round_en)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

    assign work = work_reg;

endmodule

`default_nettype wire
